// File: design/tfq_pkg.sv
package tfq_pkg;

  // Operation codes of a request
  typedef enum logic [2:0] {
    OP_PUSH        = 3'd0,
    OP_RENDER      = 3'd1,
    OP_FEED        = 3'd2,
    OP_PLAY        = 3'd3,
    OP_PAUSE       = 3'd4,
    OP_ANCHOR      = 3'd5,
    OP_ANCHOR_STOP = 3'd6,
    OP_STATUS      = 3'd7
  } op_e;

  // Configuration register indexes
  localparam logic [1:0] CFG_DECODER    = 2'd0;
  localparam logic [1:0] CFG_FULL_LEVEL = 2'd1;
  localparam logic [1:0] CFG_LEAD_LIMIT = 2'd2;

  localparam int unsigned CfgDataW = 40;

  // Configuration reset values
  localparam logic          DecoderRst   = 1'b1;
  localparam logic [6:0]    FullLevelRst = 7'd5;
  localparam logic [39:0]   LeadLimitRst = 40'd2000000000;

  typedef struct packed {
    op_e                opcode;
    logic signed [63:0] stamp_ns;
    logic [15:0]        buffer_tag;
    logic [62:0]        wall_time_ns;
  } req_t;

  typedef struct packed {
    logic signed [63:0] clock_ns;
    logic               show_valid;
    logic [15:0]        show_tag;
    logic [5:0]         skipped;
    logic               evicted_valid;
    logic [15:0]        evicted_tag;
    logic               buffer_full;
    logic [6:0]         fill_level;
    logic               frame_due;
  } rsp_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic elapse;
    logic clock;
    logic evict;
    logic walk;
    logic pop;
    logic apply;
    logic finish;
  } ctrl_t;

  // Datapath to controller status
  typedef struct packed {
    op_e  op;
    logic at_full;
    logic walk_last;
    logic head_due;
  } stat_t;

endpackage

// File: design/tfq_ctrl.sv
module tfq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  output logic            busy_o,
  input  tfq_pkg::stat_t  stat_i,
  output tfq_pkg::ctrl_t  ctrl_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ELAPSE,
    S_CLOCK,
    S_EVICT,
    S_WALK,
    S_POP,
    S_APPLY,
    S_FINISH
  } state_e;

  state_e state_q, state_d;
  logic   busy_q, busy_d;

  // Next state and command decode
  always_comb begin
    state_d = state_q;
    busy_d  = busy_q;
    ctrl_o  = '0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          ctrl_o.load = 1'b1;
          busy_d      = 1'b1;
          state_d     = S_ELAPSE;
        end
      end
      S_ELAPSE: begin
        ctrl_o.elapse = 1'b1;
        state_d       = S_CLOCK;
      end
      S_CLOCK: begin
        ctrl_o.clock = 1'b1;
        priority if (stat_i.op == tfq_pkg::OP_PUSH) begin
          state_d = stat_i.at_full ? S_EVICT : S_WALK;
        end else if (stat_i.op == tfq_pkg::OP_RENDER) begin
          state_d = S_POP;
        end else begin
          state_d = S_APPLY;
        end
      end
      S_EVICT: begin
        ctrl_o.evict = 1'b1;
        state_d      = S_WALK;
      end
      S_WALK: begin
        ctrl_o.walk = 1'b1;
        if (stat_i.walk_last) begin
          state_d = S_FINISH;
        end
      end
      S_POP: begin
        // drop due entries from the head one per cycle
        if (stat_i.head_due) begin
          ctrl_o.pop = 1'b1;
        end else begin
          state_d = S_FINISH;
        end
      end
      S_APPLY: begin
        ctrl_o.apply = 1'b1;
        state_d      = S_FINISH;
      end
      S_FINISH: begin
        ctrl_o.finish = 1'b1;
        busy_d        = 1'b0;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
        busy_d  = 1'b0;
      end
    endcase
  end

  // State and registered busy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      busy_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      busy_q  <= busy_d;
    end
  end

  assign busy_o = busy_q;

endmodule

// File: design/tfq_dp.sv
module tfq_dp #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tfq_pkg::req_t                 req_i,
  input  logic                          cfg_valid_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [tfq_pkg::CfgDataW-1:0]  cfg_data_i,
  input  tfq_pkg::ctrl_t                ctrl_i,
  output tfq_pkg::stat_t                stat_o,
  output tfq_pkg::rsp_t                 rsp_o,
  output logic                          done_o
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned PW = $clog2(QUEUE_DEPTH);

  // Captured request
  tfq_pkg::op_e       op_q;
  logic signed [63:0] stamp_q;
  logic [15:0]        tag_q;
  logic [62:0]        wall_q;

  // Architectural state
  logic [CW-1:0]      count_q;
  logic signed [63:0] base_q;
  logic [62:0]        resume_q;
  logic               playing_q;
  logic               pending_q;
  logic               decoder_q;
  logic [6:0]         full_level_q;
  logic [39:0]        lead_q;
  logic               done_q;

  // Entry slots, kept sorted from slot 0
  logic signed [63:0] slot_stamp_q [QUEUE_DEPTH];
  logic [15:0]        slot_tag_q   [QUEUE_DEPTH];

  // Working registers
  logic [63:0]        elapsed_q;
  logic signed [63:0] clk_q;
  logic [63:0]        diff_q;
  logic               gt_q;
  logic signed [63:0] carry_stamp_q;
  logic [15:0]        carry_tag_q;
  logic               ins_q;
  logic [PW-1:0]      pos_q;
  logic [5:0]         npop_q;
  logic               show_valid_q;
  logic [15:0]        show_tag_q;
  logic               ev_valid_q;
  logic [15:0]        ev_tag_q;
  logic               full_q;
  tfq_pkg::rsp_t      rsp_q;

  // Insertion walk: pick the slot that enters the tail this cycle
  logic [CW-1:0]      pos_ext;
  logic signed [63:0] emit_stamp;
  logic [15:0]        emit_tag;
  logic               swap;
  logic               pend_fin;

  assign pos_ext = CW'(pos_q);

  always_comb begin
    emit_stamp = slot_stamp_q[0];
    emit_tag   = slot_tag_q[0];
    swap       = 1'b0;
    if (pos_ext < count_q) begin
      if (ins_q || (slot_stamp_q[0] > carry_stamp_q)) begin
        emit_stamp = carry_stamp_q;
        emit_tag   = carry_tag_q;
        swap       = 1'b1;
      end
    end else if (pos_ext == count_q) begin
      emit_stamp = carry_stamp_q;
      emit_tag   = carry_tag_q;
    end
  end

  // pending flag after a render
  assign pend_fin = (op_q == tfq_pkg::OP_RENDER) ? ((count_q != '0) && playing_q)
                                                  : pending_q;

  // Status to controller
  assign stat_o.op        = op_q;
  assign stat_o.at_full   = (count_q == CW'(QUEUE_DEPTH));
  assign stat_o.walk_last = (pos_q == PW'(QUEUE_DEPTH - 1));
  assign stat_o.head_due  = (count_q != '0) && (slot_stamp_q[0] <= clk_q);

  // Control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      base_q       <= '0;
      resume_q     <= '0;
      playing_q    <= 1'b0;
      pending_q    <= 1'b0;
      decoder_q    <= tfq_pkg::DecoderRst;
      full_level_q <= tfq_pkg::FullLevelRst;
      lead_q       <= tfq_pkg::LeadLimitRst;
      done_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        if (cfg_index_i == tfq_pkg::CFG_DECODER) begin
          decoder_q <= cfg_data_i[0];
        end else if (cfg_index_i == tfq_pkg::CFG_FULL_LEVEL) begin
          full_level_q <= cfg_data_i[6:0];
        end else if (cfg_index_i == tfq_pkg::CFG_LEAD_LIMIT) begin
          lead_q <= cfg_data_i[39:0];
        end
      end
      if (ctrl_i.walk && stat_o.walk_last) begin
        count_q   <= count_q + CW'(1);
        pending_q <= 1'b1;
      end
      if (ctrl_i.evict || ctrl_i.pop) begin
        count_q <= count_q - CW'(1);
      end
      if (ctrl_i.apply) begin
        unique case (op_q)
          tfq_pkg::OP_PLAY: begin
            resume_q  <= wall_q;
            playing_q <= 1'b1;
            pending_q <= 1'b1;
          end
          tfq_pkg::OP_PAUSE: begin
            base_q    <= clk_q;
            playing_q <= 1'b0;
            pending_q <= 1'b0;
          end
          tfq_pkg::OP_ANCHOR: begin
            base_q   <= stamp_q;
            resume_q <= wall_q;
            count_q  <= '0;
          end
          tfq_pkg::OP_ANCHOR_STOP: begin
            base_q    <= stamp_q;
            resume_q  <= wall_q;
            count_q   <= '0;
            playing_q <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (ctrl_i.finish) begin
        pending_q <= pend_fin;
      end
      done_q <= ctrl_i.finish;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      op_q    <= req_i.opcode;
      stamp_q <= req_i.stamp_ns;
      tag_q   <= req_i.buffer_tag;
      wall_q  <= req_i.wall_time_ns;
    end
    if (ctrl_i.elapse) begin
      elapsed_q <= {1'b0, wall_q} - {1'b0, resume_q};
    end
    // clock at the wall time, feed difference, walk setup
    if (ctrl_i.clock) begin
      clk_q         <= base_q + (playing_q ? $signed(elapsed_q) : 64'sd0);
      diff_q        <= stamp_q - base_q;
      gt_q          <= (stamp_q > base_q);
      carry_stamp_q <= stamp_q;
      carry_tag_q   <= tag_q;
      ins_q         <= 1'b0;
      pos_q         <= '0;
      npop_q        <= '0;
      show_valid_q  <= 1'b0;
      show_tag_q    <= '0;
      ev_valid_q    <= 1'b0;
      ev_tag_q      <= '0;
      full_q        <= 1'b0;
    end
    // evict or pop: rotate the slots by one
    if (ctrl_i.evict || ctrl_i.pop) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        slot_stamp_q[i] <= slot_stamp_q[i+1];
        slot_tag_q[i]   <= slot_tag_q[i+1];
      end
      slot_stamp_q[QUEUE_DEPTH-1] <= slot_stamp_q[0];
      slot_tag_q[QUEUE_DEPTH-1]   <= slot_tag_q[0];
    end
    if (ctrl_i.evict) begin
      ev_valid_q <= 1'b1;
      ev_tag_q   <= slot_tag_q[0];
    end
    if (ctrl_i.pop) begin
      show_valid_q <= 1'b1;
      show_tag_q   <= slot_tag_q[0];
      npop_q       <= npop_q + 6'd1;
    end
    // insertion walk: one slot passes through the tail per cycle
    if (ctrl_i.walk) begin
      for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
        slot_stamp_q[i] <= slot_stamp_q[i+1];
        slot_tag_q[i]   <= slot_tag_q[i+1];
      end
      slot_stamp_q[QUEUE_DEPTH-1] <= emit_stamp;
      slot_tag_q[QUEUE_DEPTH-1]   <= emit_tag;
      if (swap) begin
        carry_stamp_q <= slot_stamp_q[0];
        carry_tag_q   <= slot_tag_q[0];
        ins_q         <= 1'b1;
      end
      pos_q <= pos_q + PW'(1);
    end
    if (ctrl_i.apply) begin
      if (op_q == tfq_pkg::OP_FEED) begin
        if (decoder_q) begin
          full_q <= (7'(count_q) >= full_level_q);
        end else begin
          full_q <= gt_q && (diff_q > {24'd0, lead_q});
        end
      end
      // clock after play or anchor restarts at the new base
      if (op_q == tfq_pkg::OP_PLAY) begin
        clk_q <= base_q;
      end else if (op_q == tfq_pkg::OP_ANCHOR || op_q == tfq_pkg::OP_ANCHOR_STOP) begin
        clk_q <= stamp_q;
      end
    end
    if (ctrl_i.finish) begin
      rsp_q.clock_ns      <= clk_q;
      rsp_q.show_valid    <= show_valid_q;
      rsp_q.show_tag      <= show_tag_q;
      rsp_q.skipped       <= show_valid_q ? (npop_q - 6'd1) : 6'd0;
      rsp_q.evicted_valid <= ev_valid_q;
      rsp_q.evicted_tag   <= ev_tag_q;
      rsp_q.buffer_full   <= full_q;
      rsp_q.fill_level    <= 7'(count_q);
      rsp_q.frame_due     <= pend_fin;
    end
  end

  assign rsp_o  = rsp_q;
  assign done_o = done_q;

endmodule

// File: design/timestamp_ordered_frame_queue.sv
// Channel   Direction  Signals                                   Transfer
// request   in         start_i, busy_o, req_i                    start_i && !busy_o
// result    out        done_o, rsp_o                             done_o, one cycle
// config    in         cfg_valid_i, cfg_ready_o, cfg_index_i,    cfg_valid_i && cfg_ready_o
//                      cfg_data_i
//
// A request steps through load, elapse and clock, then apply (feed, play, pause, anchor,
// status), a pop per due entry (render), or an optional evict and the insertion walk (push),
// then finish; the insertion walk rotates every slot once through the queue tail.
// The result shows on rsp_o for one cycle with done_o; the receiver cannot stall it.
// Reset is asynchronous, active low; the queue is empty and the clock is paused at zero.
// busy_o is high from acceptance until the result cycle; config writes wait while busy.
module timestamp_ordered_frame_queue #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  tfq_pkg::req_t                 req_i,
  output logic                          done_o,
  output tfq_pkg::rsp_t                 rsp_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [1:0]                    cfg_index_i,
  input  logic [tfq_pkg::CfgDataW-1:0]  cfg_data_i
);

  tfq_pkg::ctrl_t ctrl;
  tfq_pkg::stat_t stat;

  // config writes are taken only while no request is in flight
  assign cfg_ready_o = ~busy_o;

  tfq_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .busy_o  (busy_o),
    .stat_i  (stat),
    .ctrl_o  (ctrl)
  );

  tfq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .rsp_o       (rsp_o),
    .done_o      (done_o)
  );

endmodule

// File: bench/frame_queue_checker.sv
`timescale 1ns / 1ps

// Watches the request, result and config channels of the frame queue, keeps its own
// copy of the queue, clock and registers, and compares each result with the oldest
// outstanding expectation.
module frame_queue_checker #(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  tfq_pkg::req_t                 req_i,
  input  logic                          done_i,
  input  tfq_pkg::rsp_t                 rsp_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [1:0]                    cfg_index_i,
  input  logic [tfq_pkg::CfgDataW-1:0]  cfg_data_i,
  output int unsigned                   mismatches_o,
  output int unsigned                   results_owed_o
);

  // Shadow of the frame queue and presentation clock
  logic [63:0] slot_stamp [QUEUE_DEPTH];
  logic [15:0] slot_tag   [QUEUE_DEPTH];
  int unsigned held;
  logic [63:0] base_ns;
  logic [63:0] resume_ns;
  logic        playing;
  logic        due_pending;

  // Shadow of the config registers
  logic        decoder_on;
  logic [6:0]  level_mark;
  logic [39:0] lead_ns;

  tfq_pkg::rsp_t owed_q [$];
  tfq_pkg::rsp_t owed;
  tfq_pkg::rsp_t fresh;
  int unsigned   fail_tally;

  function automatic logic [63:0] clock_at(logic [63:0] wall);
    return base_ns + (playing ? wall - resume_ns : 64'd0);
  endfunction

  // Remove the n oldest entries
  task automatic drop_oldest(int unsigned n);
    for (int unsigned i = 0; i + n < held; i++) begin
      slot_stamp[i] = slot_stamp[i + n];
      slot_tag[i]   = slot_tag[i + n];
    end
    held -= n;
  endtask

  // Apply one request to the shadow state and work out its result
  task automatic predict_frame_result(input tfq_pkg::req_t r, output tfq_pkg::rsp_t e);
    logic [63:0] stamp;
    logic [63:0] wall;
    logic [63:0] now;
    int unsigned n;
    int unsigned at;
    e     = '0;
    stamp = r.stamp_ns;
    wall  = {1'b0, r.wall_time_ns};
    case (r.opcode)
      tfq_pkg::OP_PUSH: begin
        if (held >= QUEUE_DEPTH) begin
          e.evicted_valid = 1'b1;
          e.evicted_tag   = slot_tag[0];
          drop_oldest(1);
        end
        // insert after every entry with an equal or earlier stamp
        at = held;
        while (at > 0 && $signed(slot_stamp[at - 1]) > $signed(stamp)) begin
          slot_stamp[at] = slot_stamp[at - 1];
          slot_tag[at]   = slot_tag[at - 1];
          at--;
        end
        slot_stamp[at] = stamp;
        slot_tag[at]   = r.buffer_tag;
        held++;
        due_pending = 1'b1;
      end
      tfq_pkg::OP_RENDER: begin
        now = clock_at(wall);
        n   = 0;
        while (n < held && $signed(slot_stamp[n]) <= $signed(now)) n++;
        if (n > 0) begin
          e.show_valid = 1'b1;
          e.show_tag   = slot_tag[n - 1];
          e.skipped    = 6'(n - 1);
          drop_oldest(n);
        end
        due_pending = (held > 0) && playing;
      end
      tfq_pkg::OP_FEED: begin
        if (decoder_on) begin
          e.buffer_full = (held >= level_mark);
        end else if ($signed(stamp) <= $signed(base_ns)) begin
          e.buffer_full = 1'b0;
        end else begin
          // stamp leads base here, so the unsigned difference is exact
          e.buffer_full = (stamp - base_ns) > {24'd0, lead_ns};
        end
      end
      tfq_pkg::OP_PLAY: begin
        resume_ns   = wall;
        playing     = 1'b1;
        due_pending = 1'b1;
      end
      tfq_pkg::OP_PAUSE: begin
        if (playing) base_ns += wall - resume_ns;
        playing     = 1'b0;
        due_pending = 1'b0;
      end
      tfq_pkg::OP_ANCHOR, tfq_pkg::OP_ANCHOR_STOP: begin
        if (r.opcode == tfq_pkg::OP_ANCHOR_STOP) playing = 1'b0;
        base_ns   = stamp;
        resume_ns = wall;
        held      = 0;
      end
      default: begin
      end
    endcase
    e.clock_ns   = clock_at(wall);
    e.fill_level = 7'(held);
    e.frame_due  = due_pending;
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
      fail_tally++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held        = 0;
      base_ns     = '0;
      resume_ns   = '0;
      playing     = 1'b0;
      due_pending = 1'b0;
      decoder_on  = tfq_pkg::DecoderRst;
      level_mark  = tfq_pkg::FullLevelRst;
      lead_ns     = tfq_pkg::LeadLimitRst;
      fail_tally  = 0;
      owed_q.delete();
      mismatches_o   <= 0;
      results_owed_o <= 0;
    end else begin
      // result side
      if (done_i === 1'b1) begin
        if (owed_q.size() == 0) begin
          $error("result with no request outstanding: 0x%0h", rsp_i);
          fail_tally++;
        end else begin
          owed = owed_q.pop_front();
          check_field("clock_ns",      owed.clock_ns,           rsp_i.clock_ns);
          check_field("show_valid",    64'(owed.show_valid),    64'(rsp_i.show_valid));
          check_field("show_tag",      64'(owed.show_tag),      64'(rsp_i.show_tag));
          check_field("skipped",       64'(owed.skipped),       64'(rsp_i.skipped));
          check_field("evicted_valid", 64'(owed.evicted_valid), 64'(rsp_i.evicted_valid));
          check_field("evicted_tag",   64'(owed.evicted_tag),   64'(rsp_i.evicted_tag));
          check_field("buffer_full",   64'(owed.buffer_full),   64'(rsp_i.buffer_full));
          check_field("fill_level",    64'(owed.fill_level),    64'(rsp_i.fill_level));
          check_field("frame_due",     64'(owed.frame_due),     64'(rsp_i.frame_due));
        end
      end

      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          tfq_pkg::CFG_DECODER:    decoder_on = cfg_data_i[0];
          tfq_pkg::CFG_FULL_LEVEL: level_mark = cfg_data_i[6:0];
          tfq_pkg::CFG_LEAD_LIMIT: lead_ns    = cfg_data_i[39:0];
          default: begin
          end
        endcase
      end

      // request side
      if (start_i && !busy_i) begin
        predict_frame_result(req_i, fresh);
        owed_q.push_back(fresh);
      end

      mismatches_o   <= fail_tally;
      results_owed_o <= owed_q.size();
    end
  end

endmodule

// File: bench/timestamp_ordered_frame_queue_tb.sv
`timescale 1ns / 1ps

module timestamp_ordered_frame_queue_tb;

  localparam int unsigned RandomItems   = 700;
  localparam int unsigned PhaseCount    = 8;
  localparam int unsigned SettleCycles  = 24;
  localparam int unsigned FramePeriodNs = 16_666_667;
  localparam logic [39:0] LeadMax       = '1;
  localparam logic [63:0] StampMax      = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] StampMin      = 64'h8000_0000_0000_0000;
  localparam logic [62:0] WallMax       = '1;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         start_i;
  logic                         busy_o;
  tfq_pkg::req_t                req_i;
  logic                         done_o;
  tfq_pkg::rsp_t                rsp_o;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [1:0]                   cfg_index_i;
  logic [tfq_pkg::CfgDataW-1:0] cfg_data_i;
  int unsigned                  mismatches;
  int unsigned                  results_owed;

  // Stream state used to shape well-formed traffic
  logic [62:0] wall_now;
  logic [63:0] anchor_stamp;
  logic [63:0] next_frame;
  logic [39:0] lead_now;
  bit          no_idle;

  timestamp_ordered_frame_queue dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .req_i       (req_i),
    .done_o      (done_o),
    .rsp_o       (rsp_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  frame_queue_checker u_frame_check (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .req_i          (req_i),
    .done_i         (done_o),
    .rsp_i          (rsp_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatches_o   (mismatches),
    .results_owed_o (results_owed)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Mostly no gap, some short ones, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(5, 40);
  endfunction

  // Hold a request until accepted, then idle for a random gap
  task automatic issue_request(tfq_pkg::op_e op, logic [63:0] stamp, logic [15:0] tag,
                               logic [62:0] wall);
    int unsigned gap;
    start_i <= 1'b1;
    req_i   <= '{opcode: op, stamp_ns: stamp, buffer_tag: tag, wall_time_ns: wall};
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Stop sending and wait until every result is back
  task automatic wait_idle();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (results_owed != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] index, logic [tfq_pkg::CfgDataW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic apply_setting(logic decoder, logic [6:0] level, logic [39:0] lead);
    write_reg(tfq_pkg::CFG_DECODER, tfq_pkg::CfgDataW'(decoder));
    write_reg(tfq_pkg::CFG_FULL_LEVEL, tfq_pkg::CfgDataW'(level));
    write_reg(tfq_pkg::CFG_LEAD_LIMIT, tfq_pkg::CfgDataW'(lead));
    cfg_valid_i <= 1'b0;
    lead_now = lead;
  endtask

  function automatic logic [63:0] pick_anchor();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 64'($urandom);
    if (r < 80) return StampMax - 64'($urandom_range(0, 200_000_000));
    if (r < 90) return StampMin + 64'($urandom_range(0, 200_000_000));
    return -64'($urandom);
  endfunction

  // One well-formed request inside a playing stream, or a random one
  task automatic stream_item();
    int unsigned  r;
    logic [63:0]  stamp;
    tfq_pkg::op_e op;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      issue_request(tfq_pkg::op_e'($urandom_range(0, 7)), {$urandom, $urandom},
                    16'($urandom), 63'({$urandom, $urandom}));
    end else begin
      wall_now += 63'($urandom_range(0, 25_000_000));
      stamp = {$urandom, $urandom};
      r = $urandom_range(0, 99);
      if (r < 42) begin
        op = tfq_pkg::OP_PUSH;
        r  = $urandom_range(0, 99);
        if (r < 75) begin
          stamp = next_frame;
          next_frame += 64'(FramePeriodNs);
        end else if (r < 85) begin
          stamp = next_frame - 64'(FramePeriodNs);
        end else if (r < 95) begin
          stamp = next_frame - 64'($urandom_range(0, 5 * FramePeriodNs));
        end else begin
          stamp = next_frame + 64'($urandom_range(0, 100 * FramePeriodNs));
        end
      end else if (r < 67) begin
        op = tfq_pkg::OP_RENDER;
      end else if (r < 79) begin
        op = tfq_pkg::OP_FEED;
        r  = $urandom_range(0, 99);
        // mostly around the lead boundary, relative to the last anchor; else the next frame or random
        if (r < 60) begin
          stamp = anchor_stamp + {24'd0, lead_now} + 64'($urandom_range(0, 2)) - 64'd1;
        end else if (r < 80) begin
          stamp = next_frame;
        end
      end else if (r < 84) begin
        op = tfq_pkg::OP_PLAY;
      end else if (r < 88) begin
        op = tfq_pkg::OP_PAUSE;
      end else if (r < 93) begin
        op = tfq_pkg::OP_STATUS;
      end else begin
        op = (r < 96) ? tfq_pkg::OP_ANCHOR : tfq_pkg::OP_ANCHOR_STOP;
        anchor_stamp = pick_anchor();
        next_frame   = anchor_stamp;
        stamp        = anchor_stamp;
      end
      issue_request(op, stamp, 16'($urandom), wall_now);
    end
    // sometimes let the block drain completely
    if ($urandom_range(0, 99) < 2) wait_idle();
  endtask

  // Streams: anchor, usually play, then a burst of traffic
  task automatic run_streams(int unsigned count);
    int unsigned sent;
    int unsigned burst;
    sent = 0;
    while (sent < count) begin
      no_idle      = ($urandom_range(0, 3) == 0);
      anchor_stamp = pick_anchor();
      next_frame   = anchor_stamp;
      wall_now    += 63'($urandom_range(0, 1_000_000));
      issue_request(tfq_pkg::OP_ANCHOR_STOP, anchor_stamp, 16'($urandom), wall_now);
      sent++;
      if ($urandom_range(0, 4) != 0) begin
        issue_request(tfq_pkg::OP_PLAY, {$urandom, $urandom}, 16'($urandom), wall_now);
        sent++;
      end
      burst = $urandom_range(8, 40);
      for (int unsigned i = 0; i < burst && sent < count; i++) begin
        stream_item();
        sent++;
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    req_i        = '0;
    cfg_valid_i  = 1'b0;
    cfg_index_i  = '0;
    cfg_data_i   = '0;
    wall_now     = '0;
    anchor_stamp = '0;
    next_frame   = '0;
    lead_now     = tfq_pkg::LeadLimitRst;
    no_idle      = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset settings, empty queue, paused clock at zero
    issue_request(tfq_pkg::OP_STATUS, 64'd0, 16'h0000, 63'd0);
    issue_request(tfq_pkg::OP_FEED,   64'd0, 16'h0000, 63'd0);
    // fill with equal, out-of-order and extreme stamps
    issue_request(tfq_pkg::OP_PUSH, 64'd100,  16'h0001, 63'd0);
    issue_request(tfq_pkg::OP_PUSH, 64'd50,   16'h0002, 63'd0);
    issue_request(tfq_pkg::OP_PUSH, 64'd100,  16'h0003, 63'd0);
    issue_request(tfq_pkg::OP_PUSH, StampMin, 16'h0000, 63'd0);
    issue_request(tfq_pkg::OP_PUSH, StampMax, 16'hFFFF, 63'd0);
    issue_request(tfq_pkg::OP_PUSH, '1,       16'h0005, 63'd0);
    issue_request(tfq_pkg::OP_PUSH, 64'd0,    16'h0006, 63'd0);
    issue_request(tfq_pkg::OP_PUSH, 64'd75,   16'h0007, 63'd0);
    issue_request(tfq_pkg::OP_FEED, 64'd0,    16'h0000, 63'd0);
    // queue full: the oldest entry goes out first
    issue_request(tfq_pkg::OP_PUSH, 64'd100,  16'h0008, 63'd0);
    issue_request(tfq_pkg::OP_RENDER, 64'd0, 16'h0000, 63'd10);
    issue_request(tfq_pkg::OP_PLAY,   64'd0, 16'h0000, 63'd1000);
    issue_request(tfq_pkg::OP_RENDER, 64'd0, 16'h0000, 63'd1100);
    issue_request(tfq_pkg::OP_PAUSE,  64'd0, 16'h0000, 63'd2000);
    issue_request(tfq_pkg::OP_STATUS, StampMax, 16'hFFFF, WallMax);
    // wall behind the resume point wraps the clock
    issue_request(tfq_pkg::OP_PLAY,   64'd0, 16'h0000, WallMax);
    issue_request(tfq_pkg::OP_RENDER, 64'd0, 16'h0000, 63'd0);
    issue_request(tfq_pkg::OP_ANCHOR, StampMax, 16'h0000, 63'd5);
    issue_request(tfq_pkg::OP_RENDER, 64'd0, 16'h0000, 63'd5);
    issue_request(tfq_pkg::OP_ANCHOR_STOP, StampMin, 16'h0000, 63'd7);
    issue_request(tfq_pkg::OP_PUSH, StampMin, 16'h1234, 63'd8);
    issue_request(tfq_pkg::OP_RENDER, 64'd0, 16'h0000, 63'd9);
    issue_request(tfq_pkg::OP_FEED, StampMax, 16'h0000, 63'd9);
    wall_now = 63'd1_000_000;

    // Random streams under a series of register settings
    for (int unsigned ph = 0; ph < PhaseCount; ph++) begin
      if (ph > 0) begin
        wait_idle();
        case (ph)
          1: apply_setting(1'b1, 7'd0,   40'd0);
          2: apply_setting(1'b1, 7'd127, LeadMax);
          3: apply_setting(1'b0, 7'd8,   40'd0);
          4: apply_setting(1'b0, 7'd64,  LeadMax);
          5: apply_setting(1'b0, 7'd1,   40'd2_000_000_000);
          6: apply_setting(1'b1, 7'($urandom_range(1, 8)), 40'({$urandom, $urandom}));
          default: apply_setting(1'b0, 7'($urandom), 40'($urandom_range(0, 100_000_000)));
        endcase
      end
      run_streams(RandomItems / PhaseCount);
    end

    wait_idle();
    if (mismatches == 0 && results_owed == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: timestamp_ordered_frame_queue.f
design/tfq_pkg.sv
design/tfq_ctrl.sv
design/tfq_dp.sv
design/timestamp_ordered_frame_queue.sv
bench/frame_queue_checker.sv
bench/timestamp_ordered_frame_queue_tb.sv
